@@ hdl/file_block_table_engine_assert.svh @@
// Assertion macros shared by the file table engine.
`ifndef FILE_BLOCK_TABLE_ENGINE_ASSERT_SVH
`define FILE_BLOCK_TABLE_ENGINE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FBT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fbt check failed");

// Next-cycle implication, checked outside reset.
`define FBT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fbt check failed");

`endif

@@ hdl/fbt_pkg.sv @@
// Types, constants and helpers of the file table engine.
`timescale 1ns / 1ps
`default_nettype none
package fbt_pkg;

  localparam int NUM_BLOCKS      = 128;
  localparam int NUM_ENTRIES     = 16;
  localparam int MAX_FILE_BLOCKS = 8;

  localparam int MODE_W   = 2;
  localparam int NAME_W   = 64;
  localparam int ARG_W    = 4;
  localparam int STATUS_W = 3;
  localparam int ADDR_W   = 7;
  localparam int SIZE_W   = 4;

  localparam int BLK_W      = $clog2(NUM_BLOCKS);
  localparam int ENT_W      = $clog2(NUM_ENTRIES);
  localparam int SLOT_W     = (MAX_FILE_BLOCKS > 1) ? $clog2(MAX_FILE_BLOCKS) : 1;
  localparam int PTR_AW     = ENT_W + SLOT_W;
  localparam int PTR_DEPTH  = NUM_ENTRIES * (2 ** SLOT_W);
  localparam int CNT_W      = $clog2(MAX_FILE_BLOCKS + 1);
  localparam int FREE_W     = $clog2(NUM_BLOCKS + 1);
  localparam int CHUNK      = 8;
  localparam int BIT_W      = $clog2(CHUNK);
  localparam int NUM_CHUNKS = NUM_BLOCKS / CHUNK;
  localparam int CHK_W      = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_CREATE = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_MAP    = 2'd2,
    MODE_LIST   = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NO_SPACE  = 3'd1,
    ST_NO_ENTRY  = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_BAD_INDEX = 3'd4,
    ST_TOO_LARGE = 3'd5,
    ST_NO_FILES  = 3'd6
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PASS,
    S_DECIDE,
    S_ALLOC,
    S_FREE_RD,
    S_FREE_CLR,
    S_MAP_DATA,
    S_RESP,
    S_LIST_END
  } state_e;

  typedef struct packed {
    logic              used;
    logic [NAME_W-1:0] name_high;
    logic [NAME_W-1:0] name_low;
    logic [SIZE_W-1:0] size;
  } entry_t;

  // Position of the lowest clear bit of a bitmap chunk.
  function automatic logic [BIT_W-1:0] lowest_free(input logic [CHUNK-1:0] c);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = CHUNK - 1; i >= 0; i--) begin
      if (!c[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hdl/fbt_if.sv @@
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps
`default_nettype none
interface fbt_in_if;
  logic                       valid;
  logic                       ready;
  logic [fbt_pkg::MODE_W-1:0] mode;
  logic [fbt_pkg::NAME_W-1:0] name_high;
  logic [fbt_pkg::NAME_W-1:0] name_low;
  logic [fbt_pkg::ARG_W-1:0]  size_or_index;
  modport source (output valid, mode, name_high, name_low, size_or_index, input ready);
  modport sink (input valid, mode, name_high, name_low, size_or_index, output ready);
endinterface

interface fbt_out_if;
  logic                         valid;
  logic                         ready;
  logic [fbt_pkg::STATUS_W-1:0] status;
  logic [fbt_pkg::ADDR_W-1:0]   block_address;
  logic [fbt_pkg::NAME_W-1:0]   file_name_high;
  logic [fbt_pkg::NAME_W-1:0]   file_name_low;
  logic [fbt_pkg::SIZE_W-1:0]   file_size;
  logic                         last;
  modport source (output valid, status, block_address, file_name_high, file_name_low,
                  file_size, last, input ready);
  modport sink (input valid, status, block_address, file_name_high, file_name_low,
                file_size, last, output ready);
endinterface
`default_nettype wire

@@ hdl/fbt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module fbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

@@ hdl/fbt_cell.sv @@
// One file table entry in the rotating chain of entries.
`timescale 1ns / 1ps
`default_nettype none
module fbt_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            shift_i,
  input  wire fbt_pkg::entry_t entry_i,
  output fbt_pkg::entry_t      entry_o
);
  logic                                  used_q;
  logic [2*fbt_pkg::NAME_W+fbt_pkg::SIZE_W-1:0] data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else if (shift_i) begin
      used_q <= entry_i.used;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) data_q <= {entry_i.name_high, entry_i.name_low, entry_i.size};
  end

  assign entry_o = {used_q, data_q};
endmodule
`default_nettype wire

@@ hdl/file_block_table_engine.sv @@
// File table engine: a chain of entry cells plus a block bitmap allocator.
// One item at a time. Every request except an early create rejection rotates the
// entry chain once, then decides and answers. Create then allocates one block a
// cycle while scanning 8-bit bitmap chunks, except in a cycle that steps past a
// full chunk. Delete reads each freed block from the pointer RAM, then clears its
// bitmap bit; list gives one result a cycle unless an older result cannot leave.
// Reset empties the table and frees every block but block zero, at once.
`timescale 1ns / 1ps
`default_nettype none
`include "file_block_table_engine_assert.svh"
module file_block_table_engine (
  input wire logic clk_i,
  input wire logic rst_ni,
  fbt_in_if.sink   in_i,
  fbt_out_if.source out_o
);
  localparam int NE = fbt_pkg::NUM_ENTRIES;

  fbt_pkg::state_e  state_q, state_d;
  fbt_pkg::mode_e   op_mode_q, op_mode_d;
  logic [fbt_pkg::NAME_W-1:0] op_nh_q, op_nh_d, op_nl_q, op_nl_d;
  logic [fbt_pkg::ARG_W-1:0]  op_arg_q, op_arg_d;

  logic [fbt_pkg::ENT_W-1:0]  k_q, k_d, slot_q, slot_d;
  logic                        found_q, found_d;
  logic [fbt_pkg::SIZE_W-1:0] fsize_q, fsize_d;
  logic [fbt_pkg::CNT_W-1:0]  j_q, j_d;
  logic [fbt_pkg::CHK_W-1:0]  chk_q, chk_d;
  logic [fbt_pkg::NUM_BLOCKS-1:0] bitmap_q, bitmap_d;
  logic [fbt_pkg::FREE_W-1:0] free_q, free_d;
  fbt_pkg::status_e           resp_st_q, resp_st_d;
  logic [fbt_pkg::ADDR_W-1:0] resp_addr_q, resp_addr_d;
  logic                        lst_valid_q, lst_valid_d;
  fbt_pkg::entry_t             lst_q, lst_d;

  logic                          out_valid_q, out_valid_d;
  fbt_pkg::status_e              out_st_q, out_st_d;
  logic [fbt_pkg::ADDR_W-1:0]   out_addr_q, out_addr_d;
  logic [fbt_pkg::NAME_W-1:0]   out_nh_q, out_nh_d, out_nl_q, out_nl_d;
  logic [fbt_pkg::SIZE_W-1:0]   out_size_q, out_size_d;
  logic                          out_last_q, out_last_d;

  fbt_pkg::entry_t chain [NE+1];
  fbt_pkg::entry_t head, tail;
  logic            shift;
  logic            out_free;
  logic            match;
  logic [fbt_pkg::CHUNK-1:0] chunk;
  logic [fbt_pkg::BIT_W-1:0] fbit;

  logic                        ram_we;
  logic [fbt_pkg::PTR_AW-1:0]  ram_waddr, ram_raddr;
  logic [fbt_pkg::BLK_W-1:0]   ram_wdata, ram_rdata;

  // Cell i takes from cell i+1; the last cell takes the possibly edited head.
  assign chain[NE] = tail;
  assign head      = chain[0];
  for (genvar g = 0; g < NE; g++) begin : g_cell
    fbt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .entry_i (chain[g+1]),
      .entry_o (chain[g])
    );
  end

  fbt_ram #(
    .WIDTH (fbt_pkg::BLK_W),
    .DEPTH (fbt_pkg::PTR_DEPTH)
  ) u_ptr_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free = !out_valid_q || out_o.ready;
  assign match    = head.used && (head.name_high == op_nh_q) && (head.name_low == op_nl_q);
  assign chunk    = bitmap_q[chk_q*fbt_pkg::CHUNK +: fbt_pkg::CHUNK];
  assign fbit     = fbt_pkg::lowest_free(chunk);

  assign in_i.ready = (state_q == fbt_pkg::S_IDLE);

  always_comb begin
    state_d     = state_q;
    op_mode_d   = op_mode_q;
    op_nh_d     = op_nh_q;
    op_nl_d     = op_nl_q;
    op_arg_d    = op_arg_q;
    k_d         = k_q;
    slot_d      = slot_q;
    found_d     = found_q;
    fsize_d     = fsize_q;
    j_d         = j_q;
    chk_d       = chk_q;
    bitmap_d    = bitmap_q;
    free_d      = free_q;
    resp_st_d   = resp_st_q;
    resp_addr_d = resp_addr_q;
    lst_valid_d = lst_valid_q;
    lst_d       = lst_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_st_d    = out_st_q;
    out_addr_d  = out_addr_q;
    out_nh_d    = out_nh_q;
    out_nl_d    = out_nl_q;
    out_size_d  = out_size_q;
    out_last_d  = out_last_q;
    shift       = 1'b0;
    tail        = head;
    ram_we      = 1'b0;
    ram_waddr   = {slot_q, j_q[fbt_pkg::SLOT_W-1:0]};
    ram_wdata   = fbt_pkg::BLK_W'({chk_q, fbit});
    ram_raddr   = {slot_q, j_q[fbt_pkg::SLOT_W-1:0]};

    unique case (state_q)
      fbt_pkg::S_IDLE: begin
        if (in_i.valid) begin
          op_mode_d   = fbt_pkg::mode_e'(in_i.mode);
          op_nh_d     = in_i.name_high;
          op_nl_d     = in_i.name_low;
          op_arg_d    = in_i.size_or_index;
          k_d         = '0;
          found_d     = 1'b0;
          lst_valid_d = 1'b0;
          resp_addr_d = '0;
          state_d     = fbt_pkg::S_PASS;
          if (fbt_pkg::mode_e'(in_i.mode) == fbt_pkg::MODE_CREATE) begin
            if (int'(in_i.size_or_index) > fbt_pkg::MAX_FILE_BLOCKS) begin
              resp_st_d = fbt_pkg::ST_TOO_LARGE;
              state_d   = fbt_pkg::S_RESP;
            end else if (int'(in_i.size_or_index) > int'(free_q)) begin
              resp_st_d = fbt_pkg::ST_NO_SPACE;
              state_d   = fbt_pkg::S_RESP;
            end
          end
        end
      end
      fbt_pkg::S_PASS: begin
        // A list stalls the chain while an older result cannot leave.
        if (!(op_mode_q == fbt_pkg::MODE_LIST && head.used && lst_valid_q && !out_free)) begin
          shift = 1'b1;
          case (op_mode_q) inside
            fbt_pkg::MODE_CREATE: begin
              if (!found_q && !head.used) begin
                tail    = {1'b1, op_nh_q, op_nl_q, op_arg_q};
                found_d = 1'b1;
                slot_d  = k_q;
              end
            end
            fbt_pkg::MODE_DELETE, fbt_pkg::MODE_MAP: begin
              if (!found_q && match) begin
                found_d = 1'b1;
                slot_d  = k_q;
                fsize_d = head.size;
                if (op_mode_q == fbt_pkg::MODE_DELETE) tail.used = 1'b0;
              end
            end
            default: begin
              if (head.used) begin
                if (lst_valid_q) begin
                  out_valid_d = 1'b1;
                  out_st_d    = fbt_pkg::ST_OK;
                  out_addr_d  = '0;
                  out_nh_d    = lst_q.name_high;
                  out_nl_d    = lst_q.name_low;
                  out_size_d  = lst_q.size;
                  out_last_d  = 1'b0;
                end
                lst_d       = head;
                lst_valid_d = 1'b1;
              end
            end
          endcase
          if (k_q == fbt_pkg::ENT_W'(NE - 1)) begin
            k_d     = '0;
            state_d = (op_mode_q == fbt_pkg::MODE_LIST) ? fbt_pkg::S_LIST_END
                                                        : fbt_pkg::S_DECIDE;
          end else begin
            k_d = k_q + 1'b1;
          end
        end
      end
      fbt_pkg::S_DECIDE: begin
        j_d   = '0;
        chk_d = '0;
        if (!found_q) begin
          resp_st_d = (op_mode_q == fbt_pkg::MODE_CREATE) ? fbt_pkg::ST_NO_ENTRY
                                                          : fbt_pkg::ST_NOT_FOUND;
          state_d   = fbt_pkg::S_RESP;
        end else if (op_mode_q == fbt_pkg::MODE_CREATE) begin
          fsize_d = op_arg_q;
          state_d = fbt_pkg::S_ALLOC;
        end else if (op_mode_q == fbt_pkg::MODE_DELETE) begin
          state_d = fbt_pkg::S_FREE_RD;
        end else if (op_arg_q >= fsize_q || int'(op_arg_q) >= fbt_pkg::MAX_FILE_BLOCKS) begin
          resp_st_d = fbt_pkg::ST_BAD_INDEX;
          state_d   = fbt_pkg::S_RESP;
        end else begin
          ram_raddr = {slot_q, op_arg_q[fbt_pkg::SLOT_W-1:0]};
          state_d   = fbt_pkg::S_MAP_DATA;
        end
      end
      fbt_pkg::S_ALLOC: begin
        if (int'(j_q) >= int'(fsize_q)) begin
          resp_st_d = fbt_pkg::ST_OK;
          state_d   = fbt_pkg::S_RESP;
        end else if (&chunk) begin
          chk_d = chk_q + 1'b1;
        end else begin
          ram_we                              = 1'b1;
          bitmap_d[{chk_q, fbit}]             = 1'b1;
          free_d                              = free_q - 1'b1;
          j_d                                 = j_q + 1'b1;
        end
      end
      fbt_pkg::S_FREE_RD: begin
        if (int'(j_q) >= int'(fsize_q)) begin
          resp_st_d = fbt_pkg::ST_OK;
          state_d   = fbt_pkg::S_RESP;
        end else begin
          state_d = fbt_pkg::S_FREE_CLR;
        end
      end
      fbt_pkg::S_FREE_CLR: begin
        bitmap_d[ram_rdata] = 1'b0;
        free_d              = free_q + 1'b1;
        j_d                 = j_q + 1'b1;
        state_d             = fbt_pkg::S_FREE_RD;
      end
      fbt_pkg::S_MAP_DATA: begin
        resp_st_d   = fbt_pkg::ST_OK;
        resp_addr_d = fbt_pkg::ADDR_W'(ram_rdata);
        state_d     = fbt_pkg::S_RESP;
      end
      fbt_pkg::S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_st_d    = resp_st_q;
          out_addr_d  = resp_addr_q;
          out_nh_d    = '0;
          out_nl_d    = '0;
          out_size_d  = '0;
          out_last_d  = 1'b1;
          state_d     = fbt_pkg::S_IDLE;
        end
      end
      fbt_pkg::S_LIST_END: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_addr_d  = '0;
          out_last_d  = 1'b1;
          if (lst_valid_q) begin
            out_st_d   = fbt_pkg::ST_OK;
            out_nh_d   = lst_q.name_high;
            out_nl_d   = lst_q.name_low;
            out_size_d = lst_q.size;
          end else begin
            out_st_d   = fbt_pkg::ST_NO_FILES;
            out_nh_d   = '0;
            out_nl_d   = '0;
            out_size_d = '0;
          end
          lst_valid_d = 1'b0;
          state_d     = fbt_pkg::S_IDLE;
        end
      end
      default: state_d = fbt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fbt_pkg::S_IDLE;
      k_q         <= '0;
      found_q     <= 1'b0;
      j_q         <= '0;
      chk_q       <= '0;
      bitmap_q    <= fbt_pkg::NUM_BLOCKS'(1);
      free_q      <= fbt_pkg::FREE_W'(fbt_pkg::NUM_BLOCKS - 1);
      lst_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      found_q     <= found_d;
      j_q         <= j_d;
      chk_q       <= chk_d;
      bitmap_q    <= bitmap_d;
      free_q      <= free_d;
      lst_valid_q <= lst_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_mode_q   <= op_mode_d;
    op_nh_q     <= op_nh_d;
    op_nl_q     <= op_nl_d;
    op_arg_q    <= op_arg_d;
    slot_q      <= slot_d;
    fsize_q     <= fsize_d;
    resp_st_q   <= resp_st_d;
    resp_addr_q <= resp_addr_d;
    lst_q       <= lst_d;
    out_st_q    <= out_st_d;
    out_addr_q  <= out_addr_d;
    out_nh_q    <= out_nh_d;
    out_nl_q    <= out_nl_d;
    out_size_q  <= out_size_d;
    out_last_q  <= out_last_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = out_st_q;
  assign out_o.block_address  = out_addr_q;
  assign out_o.file_name_high = out_nh_q;
  assign out_o.file_name_low  = out_nl_q;
  assign out_o.file_size      = out_size_q;
  assign out_o.last           = out_last_q;

  `FBT_ASSERT_NOW(a_free_count, 1'b1, int'(free_q) == fbt_pkg::NUM_BLOCKS - $countones(bitmap_q))
  `FBT_ASSERT_NOW(a_block0_reserved, 1'b1, bitmap_q[0])
  `FBT_ASSERT_NEXT(a_resp_done, state_q == fbt_pkg::S_RESP && out_free, state_q == fbt_pkg::S_IDLE && out_valid_q)
endmodule
`default_nettype wire
